[sv/pts_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register map, style codes and sine table builder for the
// procedural texture shader. No dependencies.
package pts_pkg;

   localparam int unsigned SINE_TABLE_DEPTH = 1024;
   localparam int unsigned SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
   localparam int unsigned SINE_QUARTER     = SINE_TABLE_DEPTH / 4;
   localparam int unsigned SINE_ROM_DEPTH   = SINE_QUARTER + 1;
   localparam int unsigned SINE_ADDR_W      = SINE_IDX_W - 1;
   localparam int unsigned SINE_LOW_W       = SINE_IDX_W - 2;
   localparam int unsigned SINE_MAG_W       = 31;

   localparam longint unsigned ONE_Q30     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam int unsigned WEIGHT_W = 17;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [2:0] REG_STYLE     = 3'd0;
   localparam logic [2:0] REG_INV_TILE  = 3'd1;
   localparam logic [2:0] REG_BASE_RED  = 3'd2;
   localparam logic [2:0] REG_BASE_GRN  = 3'd3;
   localparam logic [2:0] REG_BASE_BLUE = 3'd4;

   localparam logic [2:0] STYLE_CHECKER     = 3'd0;
   localparam logic [2:0] STYLE_STRIPES_Y   = 3'd1;
   localparam logic [2:0] STYLE_STRIPES_X   = 3'd2;
   localparam logic [2:0] STYLE_GRADIENT_XY = 3'd3;
   localparam logic [2:0] STYLE_GRADIENT_X  = 3'd4;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
   } req_type;

   typedef struct packed {
      logic [15:0] out_red;
      logic [15:0] out_green;
      logic [15:0] out_blue;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  pattern_style;
      logic [31:0] inverse_tile_size;
      logic [15:0] base_red;
      logic [15:0] base_green;
      logic [15:0] base_blue;
   } cfg_type;

   typedef logic [SINE_MAG_W-1:0] sine_rom_type [SINE_ROM_DEPTH];

   // Quarter-wave sine magnitude in unsigned Q1.30 for folded index j (0 .. quarter).
   function automatic logic [SINE_MAG_W-1:0] sine_mag(int unsigned j);
      longint unsigned turn;
      longint unsigned a;
      longint unsigned a2;
      longint unsigned h;
      longint unsigned s;
      turn = (longint'(j) << 32) / SINE_TABLE_DEPTH;
      a  = (turn * HALF_PI_Q30) >> 30;
      a2 = (a * a) >> 30;
      h  = ONE_Q30 - a2 / 72;
      h  = ONE_Q30 - ((a2 * h) >> 30) / 42;
      h  = ONE_Q30 - ((a2 * h) >> 30) / 20;
      h  = ONE_Q30 - ((a2 * h) >> 30) / 6;
      s  = (a * h) >> 30;
      if (s > ONE_Q30) begin
         s = ONE_Q30;
      end
      return s[SINE_MAG_W-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int unsigned i = 0; i < SINE_ROM_DEPTH; i++) begin
         rom[i] = sine_mag(i);
      end
      return rom;
   endfunction

   // Clip a signed Q16 weight to 0 .. 1.0.
   function automatic logic [WEIGHT_W-1:0] sat_weight(logic signed [33:0] v);
      logic [WEIGHT_W-1:0] w;
      if (v[33]) begin
         w = '0;
      end else if (v > 34'sd65536) begin
         w = WEIGHT_ONE;
      end else begin
         w = v[WEIGHT_W-1:0];
      end
      return w;
   endfunction

endpackage

[sv/pts_csr_regs.sv]
`timescale 1ns / 1ps
// Configuration register bank behind the APB-style port.
// Depends on pts_pkg for the register map and the cfg_type struct.
module pts_csr_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pts_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [pts_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pts_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output pts_pkg::cfg_type                  cfg
);

   pts_pkg::cfg_type cfg_ff;
   pts_pkg::cfg_type cfg_in;
   logic [2:0]       reg_idx;
   logic             wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[pts_pkg::CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            pts_pkg::REG_STYLE:     cfg_in.pattern_style     = pwdata[2:0];
            pts_pkg::REG_INV_TILE:  cfg_in.inverse_tile_size = pwdata;
            pts_pkg::REG_BASE_RED:  cfg_in.base_red          = pwdata[15:0];
            pts_pkg::REG_BASE_GRN:  cfg_in.base_green        = pwdata[15:0];
            pts_pkg::REG_BASE_BLUE: cfg_in.base_blue         = pwdata[15:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_style     <= pts_pkg::STYLE_CHECKER;
         cfg_ff.inverse_tile_size <= 32'd65536;
         cfg_ff.base_red          <= 16'hFFFF;
         cfg_ff.base_green        <= 16'hFFFF;
         cfg_ff.base_blue         <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         pts_pkg::REG_STYLE:     prdata = {29'd0, cfg_ff.pattern_style};
         pts_pkg::REG_INV_TILE:  prdata = cfg_ff.inverse_tile_size;
         pts_pkg::REG_BASE_RED:  prdata = {16'd0, cfg_ff.base_red};
         pts_pkg::REG_BASE_GRN:  prdata = {16'd0, cfg_ff.base_green};
         pts_pkg::REG_BASE_BLUE: prdata = {16'd0, cfg_ff.base_blue};
         default:                prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[sv/pts_sine_rom.sv]
`timescale 1ns / 1ps
// Quarter-wave sine magnitude ROM with registered read data.
// Depends on pts_pkg for the table builder and widths.
module pts_sine_rom (
   input  logic                              clock,
   input  logic [pts_pkg::SINE_ADDR_W-1:0]   rd_addr,
   output logic [pts_pkg::SINE_MAG_W-1:0]    rd_data
);

   localparam pts_pkg::sine_rom_type ROM = pts_pkg::build_sine_rom();

   logic [pts_pkg::SINE_MAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= ROM[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/procedural_texture_shader_core.sv]
`timescale 1ns / 1ps
// Procedural texture shader top level: six-stage color pipeline.
// Depends on pts_pkg, pts_csr_regs and pts_sine_rom.
//
//   channel   ports                               flow
//   request   start, busy, req_data               one request per cycle when busy is low
//   result    rsp_valid, rsp_data                 one-cycle strobe, no backpressure
//   config    psel, penable, pwrite, paddr,       APB-style, pready always high
//             pwdata, prdata, pready
//
// A new request is accepted in every cycle in which busy is low.
// Its result passes down the stage chain: input register, abs, 32x32 scale multiply,
// fold and sine ROM read, weight select, color multiply into the output register.
// Reset is synchronous: it clears all valid bits and restores the config registers;
// busy is a registered copy of reset, so it rises and falls in the cycle after reset does.
// The result side cannot stall, so the pipeline never holds.
module procedural_texture_shader_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  pts_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output pts_pkg::rsp_type                  rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pts_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [pts_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [pts_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   pts_pkg::cfg_type cfg;

   logic busy_ff;
   logic accept;

   logic               s1_valid_ff;
   logic signed [31:0] s1_x_ff;
   logic signed [31:0] s1_y_ff;

   logic               s2_valid_ff;
   logic [31:0]        s2_absx_ff;
   logic [31:0]        s2_absy_ff;
   logic               s2_negx_ff;
   logic               s2_negy_ff;
   logic signed [31:0] s2_x_ff;
   logic signed [31:0] s2_y_ff;

   logic                             s3_valid_ff;
   logic [31:0]                      s3_fracx_ff;
   logic [31:0]                      s3_fracy_ff;
   logic                             s3_negx_ff;
   logic                             s3_negy_ff;
   logic [pts_pkg::WEIGHT_W-1:0]     s3_grad_w_ff;

   logic                             s4_valid_ff;
   logic                             s4_neg_half_ff;
   logic                             s4_stripe_ff;
   logic [pts_pkg::WEIGHT_W-1:0]     s4_plain_w_ff;
   logic [pts_pkg::SINE_MAG_W-1:0]   s4_mag;

   logic                             s5_valid_ff;
   logic [pts_pkg::WEIGHT_W-1:0]     s5_weight_ff;

   logic             rsp_valid_ff;
   pts_pkg::rsp_type rsp_data_ff;

   logic [31:0]        s2_absx_in;
   logic [31:0]        s2_absy_in;
   logic [31:0]        s3_fracx_in;
   logic [31:0]        s3_fracy_in;
   logic signed [33:0] grad_v;
   logic signed [33:0] grad_sel;
   logic [pts_pkg::WEIGHT_W-1:0] s3_grad_w_in;

   logic                             flag_x;
   logic                             flag_y;
   logic [31:0]                      phase_x;
   logic [31:0]                      phase_y;
   logic [31:0]                      phase;
   logic [pts_pkg::SINE_IDX_W-1:0]   sine_idx;
   logic [1:0]                       quad;
   logic [pts_pkg::SINE_ADDR_W-1:0]  low_ext;
   logic [pts_pkg::SINE_ADDR_W-1:0]  rom_addr;
   logic [pts_pkg::WEIGHT_W-1:0]     s4_plain_w_in;
   logic                             s4_stripe_in;

   logic [31:0]                      sine_sum;
   logic [pts_pkg::WEIGHT_W-1:0]     s5_weight_in;

   logic [32:0]      prod_red;
   logic [32:0]      prod_green;
   logic [32:0]      prod_blue;
   pts_pkg::rsp_type rsp_data_in;

   pts_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // Stage 1: capture request.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_x_ff <= req_data.point_x;
      s1_y_ff <= req_data.point_y;
   end

   // Stage 2: magnitudes and signs.
   assign s2_absx_in = s1_x_ff[31] ? 32'(-s1_x_ff) : 32'(s1_x_ff);
   assign s2_absy_in = s1_y_ff[31] ? 32'(-s1_y_ff) : 32'(s1_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_absx_ff <= s2_absx_in;
      s2_absy_ff <= s2_absy_in;
      s2_negx_ff <= s1_x_ff[31];
      s2_negy_ff <= s1_y_ff[31];
      s2_x_ff    <= s1_x_ff;
      s2_y_ff    <= s1_y_ff;
   end

   // Stage 3: scale by reciprocal (fraction only), gradient weight.
   assign s3_fracx_in = s2_absx_ff * cfg.inverse_tile_size;
   assign s3_fracy_in = s2_absy_ff * cfg.inverse_tile_size;

   assign grad_v = 34'(s2_x_ff) + 34'(s2_y_ff) + 34'sd131072;

   always_comb begin
      case (cfg.pattern_style)
         pts_pkg::STYLE_GRADIENT_XY: grad_sel = grad_v >>> 2;
         pts_pkg::STYLE_GRADIENT_X:  grad_sel = 34'(s2_x_ff);
         default:                    grad_sel = 34'(s2_y_ff);
      endcase
   end

   assign s3_grad_w_in = pts_pkg::sat_weight(grad_sel);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_fracx_ff  <= s3_fracx_in;
      s3_fracy_ff  <= s3_fracy_in;
      s3_negx_ff   <= s2_negx_ff;
      s3_negy_ff   <= s2_negy_ff;
      s3_grad_w_ff <= s3_grad_w_in;
   end

   // Stage 4: checker flags, phase, quarter-wave fold, ROM read.
   assign flag_x = s3_negx_ff || !s3_fracx_ff[31];
   assign flag_y = s3_negy_ff || !s3_fracy_ff[31];

   assign phase_x = s3_negx_ff ? 32'(-s3_fracx_ff) : s3_fracx_ff;
   assign phase_y = (s3_negy_ff ? 32'(-s3_fracy_ff) : s3_fracy_ff) + 32'h4000_0000;
   assign phase   = (cfg.pattern_style == pts_pkg::STYLE_STRIPES_Y) ? phase_x : phase_y;

   assign sine_idx = phase[31 -: pts_pkg::SINE_IDX_W];
   assign quad     = sine_idx[pts_pkg::SINE_IDX_W-1 -: 2];
   assign low_ext  = {1'b0, sine_idx[pts_pkg::SINE_LOW_W-1:0]};
   assign rom_addr = quad[0]
                   ? pts_pkg::SINE_ADDR_W'(pts_pkg::SINE_QUARTER) - low_ext
                   : low_ext;

   assign s4_stripe_in = (cfg.pattern_style == pts_pkg::STYLE_STRIPES_Y)
                      || (cfg.pattern_style == pts_pkg::STYLE_STRIPES_X);
   assign s4_plain_w_in = (cfg.pattern_style == pts_pkg::STYLE_CHECKER)
                        ? ((flag_x != flag_y) ? pts_pkg::WEIGHT_ONE : '0)
                        : s3_grad_w_ff;

   pts_sine_rom u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (s4_mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_neg_half_ff <= quad[1];
      s4_stripe_ff   <= s4_stripe_in;
      s4_plain_w_ff  <= s4_plain_w_in;
   end

   // Stage 5: sine weight and final weight select.
   assign sine_sum = s4_neg_half_ff
                   ? 32'(pts_pkg::ONE_Q30) - 32'(s4_mag)
                   : 32'(pts_pkg::ONE_Q30) + 32'(s4_mag);
   assign s5_weight_in = s4_stripe_ff ? sine_sum[31:15] : s4_plain_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      s5_weight_ff <= s5_weight_in;
   end

   // Stage 6: scale base color.
   assign prod_red   = 33'(cfg.base_red)   * 33'(s5_weight_ff);
   assign prod_green = 33'(cfg.base_green) * 33'(s5_weight_ff);
   assign prod_blue  = 33'(cfg.base_blue)  * 33'(s5_weight_ff);

   assign rsp_data_in.out_red   = prod_red[31:16];
   assign rsp_data_in.out_green = prod_green[31:16];
   assign rsp_data_in.out_blue  = prod_blue[31:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s5_valid_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 6))
      else $error("result without a request six cycles earlier");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> (s5_weight_ff <= pts_pkg::WEIGHT_ONE))
      else $error("pattern weight above 1.0");

   a_sine_mag_range: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && s4_stripe_ff) |-> (33'(s4_mag) <= 33'(pts_pkg::ONE_Q30)))
      else $error("sine magnitude above 1.0");

   a_zero_weight_black: assert property (@(posedge clock) disable iff (reset)
      (s5_valid_ff && (s5_weight_ff == '0)) |=> (rsp_valid && (rsp_data == '0)))
      else $error("zero weight gave a nonzero color");

endmodule
